[rtl/core/bpa_pkg.sv]
// Package for the bitmap page allocator: sizes, codes, payload and control types.
package bpa_pkg;

  localparam int NUM_PAGES  = 256;
  localparam int NUM_BLOCKS = 16;

  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int CNT_W  = $clog2(NUM_PAGES + 1);
  localparam int BLK_W  = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;

  localparam int OP_W     = 2;
  localparam int ID_W     = 4;
  localparam int PCOUNT_W = 9;
  localparam int PIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_MISSING = 3'd3,
    ST_TAKEN   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     block_id;
    logic [PCOUNT_W-1:0] page_count;
    logic [PIDX_W-1:0]   page_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [FREE_W-1:0] free_pages;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic drain;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_req;
    logic scan_last;
  } sts_t;

endpackage

[rtl/core/bitmap_page_allocator.sv]
// Top level of the bitmap page allocator: controller and datapath.
//
// Requests enter on in_valid_i/in_ready_o with in_data_i (op, block_id, page_count,
// page_index); one result per transaction leaves on out_valid_o/out_ready_i with
// out_data_o (status, free_pages).
// A request is taken only when the allocator is idle. Allocate and free then walk
// the page table one page a cycle through the owner memory read port, passing through
// the check, scan, drain and response states before the result is valid; reserve,
// refused requests and the unused op code go from the check state straight to the
// response state. The next request can be accepted in the cycle after the result is
// loaded into the output register.
// The result sits in an output register: a new request may be accepted and worked on
// while the previous result waits; if the receiver stalls, the finished request is
// held until the output register is taken and in_ready_o stays low.
// Reset (rst_ni low, asynchronous) marks every page free, every block handle unused
// and sets the free count to NUM_PAGES; the owner table needs no clearing, as an
// owner is only read for a page marked used.
module bitmap_page_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bpa_pkg::rsp_t out_data_o
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bpa_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

[rtl/core/bpa_ctrl.sv]
// Controller state machine of the bitmap page allocator.
module bpa_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bpa_pkg::cmd_t cmd_o,
  input  bpa_pkg::sts_t sts_i
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.scan_req ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_check_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> $past(in_valid_i && in_ready_o))
    else $error("check state entered without an accepted transaction");

  a_emit_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response state");
`endif

endmodule

[rtl/core/bpa_dpath.sv]
// Datapath of the bitmap page allocator: page bitmap, owner memory, block table, counters.
module bpa_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpa_pkg::req_t in_data_i,
  output bpa_pkg::rsp_t out_data_o,
  input  bpa_pkg::cmd_t cmd_i,
  output bpa_pkg::sts_t sts_o
);
  import bpa_pkg::*;

  req_t                  req_q;
  status_e               status_q;
  status_e               check_status;
  rsp_t                  rsp_q;

  logic [NUM_PAGES-1:0]  used_q, used_d;
  logic [NUM_BLOCKS-1:0] live_q, live_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic [CNT_W-1:0]      want_q, want_d;

  logic [PAGE_W-1:0]     scan_q;
  logic                  s1_valid_q;
  logic [PAGE_W-1:0]     s1_page_q;
  logic [ID_W-1:0]       owner_rd_q;

  logic [ID_W-1:0]       owner_mem [NUM_PAGES];
  logic                  own_we;
  logic [PAGE_W-1:0]     own_waddr;

  logic                  id_in_range;
  logic                  pg_in_range;
  logic                  live_hit;
  logic [BLK_W-1:0]      blk_idx;
  logic [PAGE_W-1:0]     pg_idx;

  assign blk_idx     = BLK_W'(req_q.block_id);
  assign pg_idx      = PAGE_W'(req_q.page_index);
  assign id_in_range = 32'(req_q.block_id) < NUM_BLOCKS;
  assign pg_in_range = 32'(req_q.page_index) < NUM_PAGES;
  assign live_hit    = id_in_range && live_q[blk_idx];

  always_comb begin
    check_status = ST_OK;
    case (req_q.op)
      OP_ALLOC: begin
        if (!id_in_range || live_hit) begin
          check_status = ST_EXISTS;
        end else if (32'(req_q.page_count) > 32'(free_q)) begin
          check_status = ST_NOSPACE;
        end
      end
      OP_FREE: begin
        if (!live_hit) begin
          check_status = ST_MISSING;
        end
      end
      OP_RESERVE: begin
        if (!id_in_range) begin
          check_status = ST_EXISTS;
        end else if (!pg_in_range || used_q[pg_idx]) begin
          check_status = ST_TAKEN;
        end
      end
      default: begin
        check_status = ST_OK;
      end
    endcase
  end

  assign sts_o.scan_req  = (check_status == ST_OK) &&
                           (req_q.op == OP_ALLOC || req_q.op == OP_FREE);
  assign sts_o.scan_last = scan_q == PAGE_W'(NUM_PAGES - 1);

  always_comb begin
    used_d    = used_q;
    live_d    = live_q;
    free_d    = free_q;
    want_d    = want_q;
    own_we    = 1'b0;
    own_waddr = s1_page_q;
    if (cmd_i.check && check_status == ST_OK) begin
      case (req_q.op)
        OP_ALLOC: begin
          live_d[blk_idx] = 1'b1;
          want_d          = CNT_W'(req_q.page_count);
        end
        OP_RESERVE: begin
          used_d[pg_idx]  = 1'b1;
          own_we          = 1'b1;
          own_waddr       = pg_idx;
          free_d          = free_q - CNT_W'(1);
          live_d[blk_idx] = 1'b1;
        end
        default: ;
      endcase
    end
    if (s1_valid_q) begin
      case (req_q.op)
        OP_ALLOC: begin
          if (!used_q[s1_page_q] && want_q != '0) begin
            used_d[s1_page_q] = 1'b1;
            own_we            = 1'b1;
            free_d            = free_q - CNT_W'(1);
            want_d            = want_q - CNT_W'(1);
          end
        end
        OP_FREE: begin
          if (used_q[s1_page_q] && owner_rd_q == req_q.block_id) begin
            used_d[s1_page_q] = 1'b0;
            free_d            = free_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.drain && req_q.op == OP_FREE) begin
      live_d[blk_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      live_q     <= '0;
      free_q     <= CNT_W'(NUM_PAGES);
      scan_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      used_q     <= used_d;
      live_q     <= live_d;
      free_q     <= free_d;
      s1_valid_q <= cmd_i.scan;
      if (cmd_i.check) begin
        scan_q <= '0;
      end else if (cmd_i.scan) begin
        scan_q <= scan_q + PAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.check) begin
      status_q <= check_status;
    end
    want_q <= want_d;
    if (cmd_i.scan) begin
      s1_page_q <= scan_q;
    end
    if (cmd_i.emit) begin
      rsp_q.status     <= status_q;
      rsp_q.free_pages <= FREE_W'(free_q);
    end
  end

  // owner table: one write port, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (own_we) begin
      owner_mem[own_waddr] <= req_q.block_id;
    end
    owner_rd_q <= owner_mem[scan_q];
  end

  assign out_data_o = rsp_q;

`ifndef SYNTHESIS
  a_free_matches_bitmap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q == CNT_W'(NUM_PAGES - $countones(used_q)))
    else $error("free page count out of step with bitmap");

  a_alloc_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && req_q.op == OP_ALLOC && status_q == ST_OK) |-> (want_q == '0))
    else $error("allocate finished with pages still wanted");
`endif

endmodule
